// File: rtl/set_assoc_lru_cache_tags_macros.svh
// Assertion macros for the set-associative LRU tag store.
// Used by the top level only; no other dependencies.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH
`ifndef SYNTH
`define SALC_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define SALC_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define SALC_CHECK(label, ante, cons)
`define SALC_CHECK_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/salc_pkg.sv
// Shared types, codes and helpers for the set-associative LRU tag store.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package salc_pkg;

  localparam int TAG_W   = 62;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int ADDR_W  = 64;

  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_IFETCH = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] REG_INDEX_BITS  = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       access_outcome;
    logic             second_hit;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// File: rtl/salc_ram.sv
// Set-row store: one synchronous memory row per set holding every way.
// Depends on salc_pkg; row-written flags stand in for the cleared valid bits.
`timescale 1ns / 1ps

module salc_ram import salc_pkg::*; #(
  parameter int WAYS = 8,
  parameter int IW   = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [IW-1:0]         rd_addr,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  line_t [WAYS-1:0]      wr_row,
  output line_t [WAYS-1:0]      rd_row
);

  localparam int ROWS = 2 ** IW;

  line_t [WAYS-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_written;
  line_t [WAYS-1:0] rd_raw;
  logic             rd_live;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_raw  <= mem[rd_addr];
      rd_live <= row_written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
    end else if (wr_en) begin
      row_written[wr_addr] <= 1'b1;
    end
  end

  // A row never written since reset reads as all ways empty.
  always_comb begin
    rd_row = rd_raw;
    if (!rd_live) begin
      for (int w = 0; w < WAYS; w++) begin
        rd_row[w].valid = 1'b0;
      end
    end
  end

endmodule

// File: rtl/salc_lookup.sv
// Way compare and replacement choice for one set row, plus the updated row.
// Depends on salc_pkg; purely combinational between the row read and write back.
`timescale 1ns / 1ps

module salc_lookup import salc_pkg::*; #(
  parameter int WAYS = 8
) (
  input  line_t [WAYS-1:0]                 row,
  input  logic [TAG_W-1:0]                 tag,
  input  logic [$clog2(WAYS+1)-1:0]        ways_used,
  input  logic [STAMP_W-1:0]               stamp,
  output logic [1:0]                       outcome,
  output line_t [WAYS-1:0]                 row_next
);

  localparam int EW = $clog2(WAYS + 1);

  logic [WAYS-1:0] in_range;
  logic [WAYS-1:0] live;
  logic [WAYS-1:0] match;
  logic [WAYS-1:0] hit_oh;
  logic [WAYS-1:0] empty_oh;
  logic [WAYS-1:0] victim_oh;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      in_range[w] = EW'(w) < ways_used;
      live[w]     = in_range[w] && row[w].valid;
      match[w]    = live[w] && (row[w].tag == tag);
    end
  end

  // Lowest matching way wins.
  assign hit_oh = match & (~match + WAYS'(1));

  // Highest empty way in range.
  always_comb begin
    logic found;
    found    = 1'b0;
    empty_oh = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!found && in_range[w] && !row[w].valid) begin
        empty_oh[w] = 1'b1;
        found       = 1'b1;
      end
    end
  end

  // Oldest stamp: strictly older than every lower way, no newer than every higher way.
  always_comb begin
    logic older;
    for (int w = 0; w < WAYS; w++) begin
      older = live[w];
      for (int v = 0; v < WAYS; v++) begin
        if (v != w && live[v]) begin
          if (v < w) begin
            older = older && (row[w].stamp < row[v].stamp);
          end else begin
            older = older && (row[w].stamp <= row[v].stamp);
          end
        end
      end
      victim_oh[w] = older;
    end
  end

  always_comb begin
    row_next = row;
    if (|match) begin
      outcome = OUT_HIT;
      for (int w = 0; w < WAYS; w++) begin
        if (hit_oh[w]) begin
          row_next[w].stamp = stamp;
        end
      end
    end else if (|empty_oh) begin
      outcome = OUT_FILL;
      for (int w = 0; w < WAYS; w++) begin
        if (empty_oh[w]) begin
          row_next[w].valid = 1'b1;
          row_next[w].tag   = tag;
          row_next[w].stamp = stamp;
        end
      end
    end else begin
      outcome = OUT_EVICT;
      for (int w = 0; w < WAYS; w++) begin
        if (victim_oh[w]) begin
          row_next[w].tag   = tag;
          row_next[w].stamp = stamp;
        end
      end
    end
  end

endmodule

// File: rtl/set_assoc_lru_cache_tags.sv
// Top level of the set-associative LRU tag store: config port, sequencer, counters.
// Depends on salc_pkg, salc_ram, salc_lookup and the assertion macro header.
//
// Usage:
//   Registers index_bits, offset_bits and ways_in_use sit at byte addresses
//   0, 4 and 8 of the APB-style port; pready is always high, writes land on
//   the access cycle. Values out of range are clamped when used.
//   An access is taken when start is high and busy is low. A load, store or
//   modify reads its set row (one memory read), then compares the ways in use,
//   picks the line to fill and writes the row back in the next cycle, while
//   busy is high. The result is on result with done high for one cycle,
//   just after the write back edge; the receiver cannot stall and the next access
//   can be taken in that same cycle, so a new access is taken only after the
//   write back, set by the read then write back of the single row port.
//   An instruction fetch is accepted without a row access and gives no result.
//   Reset clears counters, the access clock and the per-row written flags, so
//   every set starts empty with no clearing pass; registers return to 4, 4, 1.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_tags_macros.svh"

module set_assoc_lru_cache_tags import salc_pkg::*; #(
  parameter int MAX_INDEX_BITS = 6,
  parameter int WAYS           = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output result_t     result
);

  localparam int IW = MAX_INDEX_BITS;
  localparam int EW = $clog2(WAYS + 1);
  localparam int SW = $clog2(MAX_INDEX_BITS + 1);

  logic [2:0] index_bits;
  logic [5:0] offset_bits;
  logic [3:0] ways_in_use;

  logic [SW-1:0] idx_use;
  logic [5:0]    off_use;
  logic [EW-1:0] ways_use;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]   access_clock;
  logic [CNT_W-1:0]   hits_kept;
  logic [CNT_W-1:0]   misses_kept;
  logic [CNT_W-1:0]   evictions_kept;
  logic [CNT_W-1:0]   clock_next;
  logic [CNT_W-1:0]   hits_step;
  logic [CNT_W-1:0]   hits_next;
  logic [CNT_W-1:0]   misses_next;
  logic [CNT_W-1:0]   evictions_next;

  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] tag_full;
  logic [IW-1:0]     set_mask;
  logic [IW-1:0]     cmd_set;
  logic [IW-1:0]     look_set;
  logic [TAG_W-1:0]  look_tag;
  logic              look_modify;

  logic accept;
  logic go;
  logic rd_en;
  logic wr_en;
  logic cfg_write;

  line_t [WAYS-1:0] rd_row;
  line_t [WAYS-1:0] row_next;
  logic [1:0]       outcome;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits  <= 3'd4;
      offset_bits <= 6'd4;
      ways_in_use <= 4'd1;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_INDEX_BITS:  index_bits  <= pwdata[2:0];
        REG_OFFSET_BITS: offset_bits <= pwdata[5:0];
        REG_WAYS_IN_USE: ways_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INDEX_BITS:  prdata = {29'd0, index_bits};
      REG_OFFSET_BITS: prdata = {26'd0, offset_bits};
      REG_WAYS_IN_USE: prdata = {28'd0, ways_in_use};
      default:         prdata = '0;
    endcase
  end

  // Clamp registers to their working ranges
  always_comb begin
    if (index_bits == 3'd0) begin
      idx_use = SW'(1);
    end else if (32'(index_bits) > MAX_INDEX_BITS) begin
      idx_use = SW'(MAX_INDEX_BITS);
    end else begin
      idx_use = SW'(index_bits);
    end

    if (offset_bits == 6'd0) begin
      off_use = 6'd1;
    end else if (offset_bits > 6'd32) begin
      off_use = 6'd32;
    end else begin
      off_use = offset_bits;
    end

    if (ways_in_use == 4'd0) begin
      ways_use = EW'(1);
    end else if (32'(ways_in_use) > WAYS) begin
      ways_use = EW'(WAYS);
    end else begin
      ways_use = EW'(ways_in_use);
    end
  end

  // Address split
  always_comb begin
    shifted  = cmd.address >> off_use;
    tag_full = shifted >> idx_use;
    for (int i = 0; i < IW; i++) begin
      set_mask[i] = SW'(i) < idx_use;
    end
    cmd_set = shifted[IW-1:0] & set_mask;
  end

  assign accept = start && !busy;
  assign go     = accept && (cmd.opcode != OP_IFETCH);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE: state_next = go ? ST_LOOK : ST_IDLE;
      ST_LOOK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // busy doubles as the interlock: no row read can meet the pending write back
  always_comb begin
    unique case (state)
      ST_IDLE: begin
        busy  = 1'b0;
        rd_en = go;
        wr_en = 1'b0;
      end
      ST_LOOK: begin
        busy  = 1'b1;
        rd_en = 1'b0;
        wr_en = 1'b1;
      end
      default: begin
        busy  = 1'b0;
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (go) begin
      look_set    <= cmd_set;
      look_tag    <= tag_full[TAG_W-1:0];
      look_modify <= cmd.opcode == OP_MODIFY;
    end
  end

  salc_ram #(
    .WAYS (WAYS),
    .IW   (IW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (cmd_set),
    .wr_en   (wr_en),
    .wr_addr (look_set),
    .wr_row  (row_next),
    .rd_row  (rd_row)
  );

  assign clock_next = sat_inc(access_clock);

  salc_lookup #(
    .WAYS (WAYS)
  ) u_lookup (
    .row       (rd_row),
    .tag       (look_tag),
    .ways_used (ways_use),
    .stamp     (clock_next),
    .outcome   (outcome),
    .row_next  (row_next)
  );

  // The second lookup of a modify always hits and leaves the stamp as is.
  always_comb begin
    hits_step      = (outcome == OUT_HIT) ? sat_inc(hits_kept) : hits_kept;
    hits_next      = look_modify ? sat_inc(hits_step) : hits_step;
    misses_next    = (outcome != OUT_HIT) ? sat_inc(misses_kept) : misses_kept;
    evictions_next = (outcome == OUT_EVICT) ? sat_inc(evictions_kept) : evictions_kept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock   <= '0;
      hits_kept      <= '0;
      misses_kept    <= '0;
      evictions_kept <= '0;
      done           <= 1'b0;
    end else begin
      done <= state == ST_LOOK;
      if (state == ST_LOOK) begin
        access_clock   <= clock_next;
        hits_kept      <= hits_next;
        misses_kept    <= misses_next;
        evictions_kept <= evictions_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOOK) begin
      result.access_outcome <= outcome;
      result.second_hit     <= look_modify;
      result.hit_total      <= hits_next;
      result.miss_total     <= misses_next;
      result.eviction_total <= evictions_next;
    end
  end

  `SALC_CHECK_NEXT(a_go_busy, start && !busy && cmd.opcode != OP_IFETCH, busy)
  `SALC_CHECK_NEXT(a_fetch_quiet, start && !busy && cmd.opcode == OP_IFETCH, !busy && !done)
  `SALC_CHECK_NEXT(a_look_done, busy, !busy && done)
  `SALC_CHECK(a_totals_kept, done, result.hit_total == hits_kept && result.miss_total == misses_kept)

endmodule
